// ===== rtl/rdc_pkg.sv =====
// Shared codes and constants for the RAM expansion DMA controller.
package rdc_pkg;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [4:0] REG_STATUS   = 5'd0;
   localparam logic [4:0] REG_COMMAND  = 5'd1;
   localparam logic [4:0] REG_HOST_LO  = 5'd2;
   localparam logic [4:0] REG_HOST_HI  = 5'd3;
   localparam logic [4:0] REG_EXP_LO   = 5'd4;
   localparam logic [4:0] REG_EXP_MID  = 5'd5;
   localparam logic [4:0] REG_EXP_BANK = 5'd6;
   localparam logic [4:0] REG_LEN_LO   = 5'd7;
   localparam logic [4:0] REG_LEN_HI   = 5'd8;
   localparam logic [4:0] REG_IRQ_MASK = 5'd9;
   localparam logic [4:0] REG_ADDR_CTL = 5'd10;

   localparam logic [1:0] MODE_STASH  = 2'd0;
   localparam logic [1:0] MODE_FETCH  = 2'd1;
   localparam logic [1:0] MODE_SWAP   = 2'd2;
   localparam logic [1:0] MODE_VERIFY = 2'd3;

   // pending one-tick actions, bit positions
   localparam int ACT_SETIRQ   = 0;
   localparam int ACT_UNSETIRQ = 1;
   localparam int ACT_SETDMA   = 2;
   localparam int ACT_FINISH   = 3;

   localparam logic [7:0] ST_IRQ    = 8'h80;
   localparam logic [7:0] ST_EOB    = 8'h40;
   localparam logic [7:0] ST_VERR   = 8'h20;
   localparam logic [7:0] LOW_FIVE  = 8'h1f;
   localparam logic [7:0] LOW_SIX   = 8'h3f;
   localparam logic [7:0] BANK_FILL = 8'hf8;
   localparam logic [7:0] OPEN_BUS  = 8'hff;

   function automatic logic irq_allowed(input logic [7:0] mask, input logic [7:0] status);
      return mask[7] && ((mask[6] && status[6]) || (mask[5] && status[5]));
   endfunction

endpackage

// ===== rtl/rdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module rdc_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_BITS = 17
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [DEPTH_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic [DEPTH_BITS-1:0] raddr,
   output logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem_ff [(1 << DEPTH_BITS)];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/ram_expansion_dma_controller.sv =====
// RAM expansion DMA controller: a request passes the processing stage, then the response register.
// Throughput one item per clock unless rsp_ready stalls the pipeline; the expansion RAM read is
// issued as an item enters and its data is used in the processing stage, where all state is updated.
// A write followed by a read of the same RAM byte is forwarded around the RAM.
// Synchronous reset restores the register file; RAM contents are not cleared.
module ram_expansion_dma_controller import rdc_pkg::*; #(
   parameter int RAM_ADDR_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_reg_addr,
   input  logic [7:0]  req_wdata,
   input  logic        req_ba_low,
   input  logic        req_cpu_ff00_write,
   input  logic [7:0]  req_host_rdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_open_bus,
   output logic [15:0] rsp_host_addr,
   output logic        rsp_host_rd,
   output logic        rsp_host_we,
   output logic [7:0]  rsp_host_wdata,
   output logic        rsp_dma_active,
   output logic        rsp_irq
);
   localparam logic [23:0] DRAM_MASK = (RAM_ADDR_BITS == 17) ? 24'h01ffff :
      ((RAM_ADDR_BITS <= 19) ? 24'h07ffff : 24'((33'h1 << RAM_ADDR_BITS) - 33'h1));
   localparam logic [19:0] WRAP_AT = (RAM_ADDR_BITS == 17) ? 20'h20000 : 20'h80000;
   localparam logic [7:0]  STATUS_RST = (RAM_ADDR_BITS > 17) ? 8'h10 : 8'h00;

   // architectural state
   logic [7:0]  status_ff, command_ff, irq_mask_ff, addr_ctl_ff;
   logic [15:0] base_host_ff, base_len_ff, host_ptr_ff, len_ff;
   logic [23:0] base_exp_ff, exp_ptr_ff;
   logic        wait_ff, steal_ff, swap_ff, dma_ff, irq_ff;
   logic [3:0]  ba_hist_ff, pend_ff;
   logic [7:0]  latch_exp_ff, latch_host_ff, floating_ff;

   logic [7:0]  status_in, command_in, irq_mask_in, addr_ctl_in;
   logic [15:0] base_host_in, base_len_in, host_ptr_in, len_in;
   logic [23:0] base_exp_in, exp_ptr_in;
   logic        wait_in, steal_in, swap_in, dma_in, irq_in;
   logic [3:0]  ba_hist_in, pend_in;
   logic [7:0]  latch_exp_in, latch_host_in, floating_in;

   // item in the processing stage
   logic        s1_valid_ff;
   logic [1:0]  s1_func_ff;
   logic [4:0]  s1_addr_ff;
   logic [7:0]  s1_wdata_ff, s1_hrdata_ff;
   logic        s1_ba_ff, s1_ff00_ff;

   // response register
   logic        rsp_valid_ff, rsp_open_bus_ff, rsp_host_rd_ff, rsp_host_we_ff;
   logic        rsp_dma_ff, rsp_irq_ff;
   logic [7:0]  rsp_rdata_ff, rsp_host_wdata_ff;
   logic [15:0] rsp_host_addr_ff;

   // RAM read tracking
   logic        rd_inrange_ff, byp_valid_ff, float_pend_ff;
   logic [7:0]  byp_data_ff;
   logic [7:0]  ram_dout, rd_data, rd_val, fb_cur;

   logic        adv, commit;
   logic        ram_we;
   logic [7:0]  ram_wd;
   logic [23:0] emask, raddr_full;
   logic [RAM_ADDR_BITS-1:0] ram_waddr;
   logic        w_inrange, r_inrange, float_set;

   logic [7:0]  o_rdata, o_hwd;
   logic        o_obus, o_hrd, o_hwe;
   logic [15:0] o_haddr, haddr;
   logic [3:0]  acts;

   function automatic logic [23:0] next_exp(input logic [23:0] e);
      logic [19:0] n;
      n = {1'b0, e[18:0]} + 20'd1;
      if (n == WRAP_AT) begin
         n = 20'd0;
      end
      return {e[23:19], n[18:0]};
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign commit    = s1_valid_ff && adv;
   assign req_ready = !s1_valid_ff || adv;

   assign rd_data = byp_valid_ff ? byp_data_ff : ram_dout;
   assign fb_cur  = (float_pend_ff && rd_inrange_ff) ? rd_data : floating_ff;
   assign rd_val  = rd_inrange_ff ? rd_data : fb_cur;

   always_comb begin
      status_in     = status_ff;
      command_in    = command_ff;
      irq_mask_in   = irq_mask_ff;
      addr_ctl_in   = addr_ctl_ff;
      base_host_in  = base_host_ff;
      base_len_in   = base_len_ff;
      base_exp_in   = base_exp_ff;
      host_ptr_in   = host_ptr_ff;
      len_in        = len_ff;
      exp_ptr_in    = exp_ptr_ff;
      wait_in       = wait_ff;
      steal_in      = steal_ff;
      swap_in       = swap_ff;
      dma_in        = dma_ff;
      irq_in        = irq_ff;
      ba_hist_in    = ba_hist_ff;
      pend_in       = pend_ff;
      latch_exp_in  = latch_exp_ff;
      latch_host_in = latch_host_ff;
      floating_in   = fb_cur;
      o_rdata = 8'd0;
      o_obus  = 1'b0;
      o_hrd   = 1'b0;
      o_hwe   = 1'b0;
      o_hwd   = 8'd0;
      haddr   = host_ptr_ff;
      ram_we  = 1'b0;
      ram_wd  = 8'd0;
      float_set = 1'b0;
      acts    = 4'd0;
      emask   = exp_ptr_ff & DRAM_MASK;

      case (s1_func_ff)
         FUNC_READ: begin
            if (dma_ff) begin
               o_rdata = OPEN_BUS;
               o_obus  = 1'b1;
            end else begin
               unique case (s1_addr_ff)
                  REG_STATUS: begin
                     o_rdata = status_ff;
                     status_in = status_ff & LOW_FIVE;
                     pend_in[ACT_UNSETIRQ] = 1'b1;
                  end
                  REG_COMMAND:  o_rdata = command_ff;
                  REG_HOST_LO:  o_rdata = host_ptr_ff[7:0];
                  REG_HOST_HI:  o_rdata = host_ptr_ff[15:8];
                  REG_EXP_LO:   o_rdata = exp_ptr_ff[7:0];
                  REG_EXP_MID:  o_rdata = exp_ptr_ff[15:8];
                  REG_EXP_BANK: o_rdata = exp_ptr_ff[23:16] | BANK_FILL;
                  REG_LEN_LO:   o_rdata = len_ff[7:0];
                  REG_LEN_HI:   o_rdata = len_ff[15:8];
                  REG_IRQ_MASK: o_rdata = irq_mask_ff | LOW_FIVE;
                  REG_ADDR_CTL: o_rdata = addr_ctl_ff | LOW_SIX;
                  default:      o_rdata = OPEN_BUS;
               endcase
            end
         end
         FUNC_WRITE: begin
            if (!dma_ff) begin
               unique case (s1_addr_ff)
                  REG_COMMAND: begin
                     command_in = s1_wdata_ff;
                     if (s1_wdata_ff[7]) begin
                        wait_in = !s1_wdata_ff[4];
                        if (s1_wdata_ff[4]) begin
                           pend_in[ACT_SETDMA] = 1'b1;
                        end
                     end
                  end
                  REG_HOST_LO: begin
                     base_host_in = {base_host_ff[15:8], s1_wdata_ff};
                     host_ptr_in  = base_host_in;
                  end
                  REG_HOST_HI: begin
                     base_host_in = {s1_wdata_ff, base_host_ff[7:0]};
                     host_ptr_in  = base_host_in;
                  end
                  REG_EXP_LO: begin
                     base_exp_in = {base_exp_ff[23:8], s1_wdata_ff};
                     exp_ptr_in  = base_exp_in;
                  end
                  REG_EXP_MID: begin
                     base_exp_in = {base_exp_ff[23:16], s1_wdata_ff, base_exp_ff[7:0]};
                     exp_ptr_in  = base_exp_in;
                  end
                  REG_EXP_BANK: begin
                     base_exp_in = {s1_wdata_ff, base_exp_ff[15:0]};
                     exp_ptr_in  = {s1_wdata_ff, exp_ptr_ff[15:0]};
                  end
                  REG_LEN_LO: begin
                     base_len_in = {base_len_ff[15:8], s1_wdata_ff};
                     len_in      = base_len_in;
                  end
                  REG_LEN_HI: begin
                     base_len_in = {s1_wdata_ff, base_len_ff[7:0]};
                     len_in      = base_len_in;
                  end
                  REG_IRQ_MASK: begin
                     irq_mask_in = s1_wdata_ff | LOW_FIVE;
                     if (irq_allowed(irq_mask_in, status_ff)) begin
                        status_in = status_ff | ST_IRQ;
                        pend_in[ACT_SETIRQ] = 1'b1;
                     end
                  end
                  REG_ADDR_CTL: addr_ctl_in = s1_wdata_ff | LOW_SIX;
                  default: ;
               endcase
            end
         end
         FUNC_TICK: begin
            acts    = pend_ff;
            pend_in = 4'd0;
            if (acts[ACT_SETIRQ]) irq_in = 1'b1;
            if (acts[ACT_UNSETIRQ]) irq_in = 1'b0;
            if (acts[ACT_SETDMA]) begin
               dma_in   = 1'b1;
               swap_in  = 1'b0;
               steal_in = 1'b0;
            end
            if (acts[ACT_FINISH]) begin
               if (command_ff[5]) begin
                  host_ptr_in = base_host_ff;
                  exp_ptr_in  = base_exp_ff;
                  len_in      = base_len_ff;
               end
               if (irq_allowed(irq_mask_ff, status_in)) begin
                  status_in = status_in | ST_IRQ;
                  irq_in = 1'b1;
               end
               command_in = (command_ff & 8'h7f) | 8'h10;
               dma_in = 1'b0;
            end
            if (wait_ff && s1_ff00_ff) begin
               wait_in = 1'b0;
               pend_in[ACT_SETDMA] = 1'b1;
            end
            ba_hist_in = {ba_hist_ff[2:0], s1_ba_ff};

            if (dma_in) begin
               haddr = host_ptr_in;
               emask = exp_ptr_in & DRAM_MASK;
               case (command_in[1:0])
                  MODE_STASH: begin
                     if (!ba_hist_in[0]) begin
                        o_hrd = 1'b1;
                        latch_exp_in = s1_hrdata_ff;
                        floating_in  = s1_hrdata_ff;
                        exp_ptr_in = emask;
                        ram_we = 1'b1;
                        ram_wd = s1_hrdata_ff;
                        if (!addr_ctl_in[7]) host_ptr_in = host_ptr_in + 16'd1;
                        if (!addr_ctl_in[6]) exp_ptr_in = next_exp(exp_ptr_in);
                        len_in = len_in - 16'd1;
                        if (len_in == 16'd0) begin
                           len_in = 16'd1;
                           status_in = status_in | ST_EOB;
                           pend_in[ACT_FINISH] = 1'b1;
                        end
                     end
                  end
                  MODE_FETCH: begin
                     if (!((ba_hist_in[1:0] == 2'b11) ||
                           (ba_hist_in[1] && len_in == base_len_in - 16'd1) ||
                           (!ba_hist_in[1] && ba_hist_in[0] && len_in == 16'd1))) begin
                        exp_ptr_in = emask;
                        latch_exp_in = rd_val;
                        floating_in  = rd_val;
                        o_hwe = 1'b1;
                        o_hwd = rd_val;
                        if (!addr_ctl_in[7]) host_ptr_in = host_ptr_in + 16'd1;
                        if (!addr_ctl_in[6]) exp_ptr_in = next_exp(exp_ptr_in);
                        if (len_in == 16'd1) begin
                           // last byte: floating bus picks up the next RAM byte
                           exp_ptr_in = exp_ptr_in & DRAM_MASK;
                           float_set = 1'b1;
                        end
                        len_in = len_in - 16'd1;
                        if (len_in == 16'd0) begin
                           len_in = 16'd1;
                           status_in = status_in | ST_EOB;
                           pend_in[ACT_FINISH] = 1'b1;
                        end
                     end
                  end
                  MODE_SWAP: begin
                     if (!swap_in) begin
                        if (!(ba_hist_in[1:0] == 2'b01 && len_in == base_len_in)) begin
                           if (ba_hist_in != 4'hf) begin
                              exp_ptr_in = emask;
                              latch_exp_in = rd_val;
                              o_hrd = 1'b1;
                              latch_host_in = s1_hrdata_ff;
                           end
                           swap_in = 1'b1;
                        end
                     end else begin
                        if (!ba_hist_in[0] || len_in == 16'd1) begin
                           exp_ptr_in = emask;
                           ram_we = 1'b1;
                           ram_wd = latch_host_ff;
                           o_hwe = 1'b1;
                           o_hwd = latch_exp_ff;
                           if (!addr_ctl_in[7]) host_ptr_in = host_ptr_in + 16'd1;
                           if (!addr_ctl_in[6]) exp_ptr_in = next_exp(exp_ptr_in);
                           len_in = len_in - 16'd1;
                           if (len_in == 16'd0) begin
                              len_in = 16'd1;
                              status_in = status_in | ST_EOB;
                              pend_in[ACT_FINISH] = 1'b1;
                           end
                        end
                        swap_in = 1'b0;
                     end
                  end
                  default: begin
                     if (!ba_hist_in[0]) begin
                        exp_ptr_in = emask;
                        latch_exp_in = rd_val;
                        o_hrd = 1'b1;
                        latch_host_in = s1_hrdata_ff;
                        if (steal_in) begin
                           // mismatch seen on an earlier compare tick: close out without counting
                           steal_in = 1'b0;
                           if (len_in == 16'd1 && rd_val == s1_hrdata_ff) begin
                              status_in = status_in | ST_EOB;
                           end
                           pend_in[ACT_FINISH] = 1'b1;
                        end else begin
                           if (!addr_ctl_in[7]) host_ptr_in = host_ptr_in + 16'd1;
                           if (!addr_ctl_in[6]) exp_ptr_in = next_exp(exp_ptr_in);
                           if (rd_val != s1_hrdata_ff) begin
                              status_in = status_in | ST_VERR;
                              if (len_in > 16'd1) steal_in = 1'b1;
                           end
                           len_in = len_in - 16'd1;
                           if (len_in == 16'd0) begin
                              len_in = 16'd1;
                              status_in = status_in | ST_EOB;
                              pend_in[ACT_FINISH] = 1'b1;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      o_haddr = (o_hrd || o_hwe) ? haddr : host_ptr_in;
   end

   assign ram_waddr  = emask[RAM_ADDR_BITS-1:0];
   assign w_inrange  = ((emask >> RAM_ADDR_BITS) == 24'd0);
   assign raddr_full = (commit ? exp_ptr_in : exp_ptr_ff) & DRAM_MASK;
   assign r_inrange  = ((raddr_full >> RAM_ADDR_BITS) == 24'd0);

   rdc_ram #(
      .WIDTH      (8),
      .DEPTH_BITS (RAM_ADDR_BITS)
   ) u_ram (
      .clock (clock),
      .we    (commit && ram_we && w_inrange),
      .waddr (ram_waddr),
      .wdata (ram_wd),
      .raddr (raddr_full[RAM_ADDR_BITS-1:0]),
      .rdata (ram_dout)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= STATUS_RST;
         command_ff    <= 8'h10;
         irq_mask_ff   <= LOW_FIVE;
         addr_ctl_ff   <= LOW_SIX;
         base_host_ff  <= 16'd0;
         base_exp_ff   <= 24'd0;
         base_len_ff   <= 16'hffff;
         host_ptr_ff   <= 16'd0;
         exp_ptr_ff    <= 24'd0;
         len_ff        <= 16'hffff;
         wait_ff       <= 1'b0;
         ba_hist_ff    <= 4'd0;
         steal_ff      <= 1'b0;
         swap_ff       <= 1'b0;
         latch_exp_ff  <= 8'hff;
         latch_host_ff <= 8'd0;
         floating_ff   <= 8'hff;
         dma_ff        <= 1'b0;
         pend_ff       <= 4'd0;
         irq_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byp_valid_ff  <= 1'b0;
         float_pend_ff <= 1'b0;
      end else begin
         byp_valid_ff  <= commit && ram_we && w_inrange && r_inrange &&
                          (ram_waddr == raddr_full[RAM_ADDR_BITS-1:0]);
         float_pend_ff <= commit && float_set;
         floating_ff   <= commit ? floating_in : fb_cur;
         if (commit) begin
            status_ff     <= status_in;
            command_ff    <= command_in;
            irq_mask_ff   <= irq_mask_in;
            addr_ctl_ff   <= addr_ctl_in;
            base_host_ff  <= base_host_in;
            base_exp_ff   <= base_exp_in;
            base_len_ff   <= base_len_in;
            host_ptr_ff   <= host_ptr_in;
            exp_ptr_ff    <= exp_ptr_in;
            len_ff        <= len_in;
            wait_ff       <= wait_in;
            ba_hist_ff    <= ba_hist_in;
            steal_ff      <= steal_in;
            swap_ff       <= swap_in;
            latch_exp_ff  <= latch_exp_in;
            latch_host_ff <= latch_host_in;
            dma_ff        <= dma_in;
            pend_ff       <= pend_in;
            irq_ff        <= irq_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_inrange_ff <= r_inrange;
      byp_data_ff   <= ram_wd;
      if (req_ready && req_valid) begin
         s1_func_ff   <= req_func;
         s1_addr_ff   <= req_reg_addr;
         s1_wdata_ff  <= req_wdata;
         s1_ba_ff     <= req_ba_low;
         s1_ff00_ff   <= req_cpu_ff00_write;
         s1_hrdata_ff <= req_host_rdata;
      end
      if (commit) begin
         rsp_rdata_ff      <= o_rdata;
         rsp_open_bus_ff   <= o_obus;
         rsp_host_addr_ff  <= o_haddr;
         rsp_host_rd_ff    <= o_hrd;
         rsp_host_we_ff    <= o_hwe;
         rsp_host_wdata_ff <= o_hwd;
         rsp_dma_ff        <= dma_in;
         rsp_irq_ff        <= irq_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rdata      = rsp_rdata_ff;
   assign rsp_open_bus   = rsp_open_bus_ff;
   assign rsp_host_addr  = rsp_host_addr_ff;
   assign rsp_host_rd    = rsp_host_rd_ff;
   assign rsp_host_we    = rsp_host_we_ff;
   assign rsp_host_wdata = rsp_host_wdata_ff;
   assign rsp_dma_active = rsp_dma_ff;
   assign rsp_irq        = rsp_irq_ff;

   a_rd_we_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_host_rd && rsp_host_we))
      else $error("host read and write in one item");

   a_open_bus_ff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_open_bus) |-> (rsp_rdata == OPEN_BUS))
      else $error("open bus read without 0xff data");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while pipeline can move");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff)
      else $error("stalled item dropped");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the RAM expansion DMA controller.
`timescale 1ns / 100ps

module tb_top;
   import rdc_pkg::*;

   localparam int RAM_BYTES = 131072;
   localparam int CYCLE_LIMIT = 100000;
   localparam int FILL_TICKS = 132;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] ra;
      logic [7:0] wd;
      logic       ba;
      logic       ff00;
      logic [7:0] hr;
      logic       drain;
      logic       settle;
   } bus_op_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        obus;
      logic [15:0] haddr;
      logic        hrd;
      logic        hwe;
      logic [7:0]  hwd;
      logic        dma;
      logic        irq;
   } bus_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_READ;
   logic [4:0]  req_reg_addr = '0;
   logic [7:0]  req_wdata = '0;
   logic        req_ba_low = 0;
   logic        req_cpu_ff00_write = 0;
   logic [7:0]  req_host_rdata = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_rdata;
   logic        rsp_open_bus;
   logic [15:0] rsp_host_addr;
   logic        rsp_host_rd;
   logic        rsp_host_we;
   logic [7:0]  rsp_host_wdata;
   logic        rsp_dma_active;
   logic        rsp_irq;

   ram_expansion_dma_controller DUT (.*);

   bus_op_type     op_queue[$];
   bus_result_type expected_q[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          cycles = 0;
   bit          stim_done = 0;

   // predictor state
   logic [7:0]  m_status, m_cmd, m_imask, m_actl;
   logic [15:0] m_base_host, m_base_len, m_hptr, m_len;
   logic [23:0] m_base_exp, m_xptr;
   logic        m_wait, m_steal, m_swap_ph, m_dma, m_irq;
   logic [3:0]  m_ba_hist, m_pend;
   logic [7:0]  m_lat_x, m_lat_h, m_float;
   logic [7:0]  m_ram[RAM_BYTES];

   function automatic void model_reset();
      m_status = 8'h00; m_cmd = 8'h10; m_imask = 8'h1f; m_actl = 8'h3f;
      m_base_host = 0; m_base_exp = 0; m_base_len = 16'hffff;
      m_hptr = 0; m_xptr = 0; m_len = 16'hffff;
      m_wait = 0; m_ba_hist = 0; m_steal = 0; m_swap_ph = 0;
      m_lat_x = 8'hff; m_lat_h = 0; m_float = 8'hff;
      m_dma = 0; m_pend = 0; m_irq = 0;
   endfunction

   function automatic logic [7:0] exp_ram_rd();
      m_xptr = m_xptr & 24'h01ffff;
      return m_ram[m_xptr[16:0]];
   endfunction

   function automatic void exp_ram_wr(input logic [7:0] v);
      m_xptr = m_xptr & 24'h01ffff;
      m_ram[m_xptr[16:0]] = v;
   endfunction

   function automatic void step_ptrs();
      logic [23:0] n;
      if (!m_actl[7]) m_hptr = m_hptr + 16'd1;
      if (m_actl[6]) return;
      n = (m_xptr & 24'h07ffff) + 24'd1;
      if (n == 24'h020000) n = 0;
      m_xptr = (m_xptr & 24'hf80000) | n;
   endfunction

   function automatic void count_byte();
      m_len = m_len - 16'd1;
      if (m_len == 0) begin
         m_len = 1;
         m_status = m_status | ST_EOB;
         m_pend[ACT_FINISH] = 1;
      end
   endfunction

   function automatic logic irq_enabled();
      return m_imask[7] && ((m_imask[6] && m_status[6]) || (m_imask[5] && m_status[5]));
   endfunction

   function automatic void end_transfer();
      if (m_cmd[5]) begin
         m_hptr = m_base_host; m_xptr = m_base_exp; m_len = m_base_len;
      end
      if (irq_enabled()) begin
         m_status = m_status | ST_IRQ;
         m_irq = 1;
      end
      m_cmd = (m_cmd & 8'h7f) | 8'h10;
      m_dma = 0;
   endfunction

   function automatic logic [7:0] read_reg(input logic [4:0] a);
      logic [7:0] v;
      case (a)
         REG_STATUS: begin
            v = m_status;
            m_status = m_status & LOW_FIVE;
            m_pend[ACT_UNSETIRQ] = 1;
            return v;
         end
         REG_COMMAND:  return m_cmd;
         REG_HOST_LO:  return m_hptr[7:0];
         REG_HOST_HI:  return m_hptr[15:8];
         REG_EXP_LO:   return m_xptr[7:0];
         REG_EXP_MID:  return m_xptr[15:8];
         REG_EXP_BANK: return m_xptr[23:16] | BANK_FILL;
         REG_LEN_LO:   return m_len[7:0];
         REG_LEN_HI:   return m_len[15:8];
         REG_IRQ_MASK: return m_imask | LOW_FIVE;
         REG_ADDR_CTL: return m_actl | LOW_SIX;
         default:      return OPEN_BUS;
      endcase
   endfunction

   function automatic void write_reg(input logic [4:0] a, input logic [7:0] v);
      case (a)
         REG_COMMAND: begin
            m_cmd = v;
            if (v[7]) begin
               m_wait = 1;
               if (v[4]) begin
                  m_pend[ACT_SETDMA] = 1;
                  m_wait = 0;
               end
            end
         end
         REG_HOST_LO: begin m_base_host[7:0] = v; m_hptr = m_base_host; end
         REG_HOST_HI: begin m_base_host[15:8] = v; m_hptr = m_base_host; end
         REG_EXP_LO: begin m_base_exp[7:0] = v; m_xptr = m_base_exp; end
         REG_EXP_MID: begin m_base_exp[15:8] = v; m_xptr = m_base_exp; end
         REG_EXP_BANK: begin
            m_base_exp[23:16] = v;
            m_xptr[23:16] = v;
         end
         REG_LEN_LO: begin m_base_len[7:0] = v; m_len = m_base_len; end
         REG_LEN_HI: begin m_base_len[15:8] = v; m_len = m_base_len; end
         REG_IRQ_MASK: begin
            m_imask = v | LOW_FIVE;
            if (irq_enabled()) begin
               m_status = m_status | ST_IRQ;
               m_pend[ACT_SETIRQ] = 1;
            end
         end
         REG_ADDR_CTL: m_actl = v | LOW_SIX;
         default: ;
      endcase
   endfunction

   function automatic bus_result_type predict_bus_op(input bus_op_type op);
      bus_result_type r;
      logic [3:0]  acts;
      logic [15:0] haddr;
      logic        skip;
      r = '0;
      haddr = m_hptr;
      if (op.func == FUNC_READ) begin
         if (m_dma) begin r.rdata = OPEN_BUS; r.obus = 1; end
         else r.rdata = read_reg(op.ra);
      end else if (op.func == FUNC_WRITE) begin
         if (!m_dma) write_reg(op.ra, op.wd);
      end else if (op.func == FUNC_TICK) begin
         acts = m_pend;
         m_pend = 0;
         if (acts[ACT_SETIRQ]) m_irq = 1;
         if (acts[ACT_UNSETIRQ]) m_irq = 0;
         if (acts[ACT_SETDMA]) begin m_dma = 1; m_swap_ph = 0; m_steal = 0; end
         if (acts[ACT_FINISH]) end_transfer();
         if (m_wait && op.ff00) begin
            m_wait = 0;
            m_pend[ACT_SETDMA] = 1;
         end
         m_ba_hist = {m_ba_hist[2:0], op.ba};
         if (m_dma) begin
            haddr = m_hptr;
            case (m_cmd[1:0])
               MODE_STASH: begin
                  if (!m_ba_hist[0]) begin
                     r.hrd = 1;
                     m_lat_x = op.hr; m_float = op.hr;
                     exp_ram_wr(op.hr);
                     step_ptrs();
                     count_byte();
                  end
               end
               MODE_FETCH: begin
                  // BA stall rules differ at the first and last byte
                  skip = (m_ba_hist[1:0] == 2'b11) ||
                         (m_ba_hist[1] ? (m_len == 16'(m_base_len - 16'd1)) :
                                         (m_ba_hist[0] && m_len == 16'd1));
                  if (!skip) begin
                     m_lat_x = exp_ram_rd();
                     m_float = m_lat_x;
                     r.hwe = 1; r.hwd = m_lat_x;
                     step_ptrs();
                     if (m_len == 16'd1) m_float = exp_ram_rd();
                     count_byte();
                  end
               end
               MODE_SWAP: begin
                  if (!m_swap_ph) begin
                     if (!(m_ba_hist[1:0] == 2'b01 && m_len == m_base_len)) begin
                        if (m_ba_hist != 4'hf) begin
                           m_lat_x = exp_ram_rd();
                           r.hrd = 1;
                           m_lat_h = op.hr;
                        end
                        m_swap_ph = 1;
                     end
                  end else begin
                     if (!m_ba_hist[0] || m_len == 16'd1) begin
                        exp_ram_wr(m_lat_h);
                        r.hwe = 1; r.hwd = m_lat_x;
                        step_ptrs();
                        count_byte();
                     end
                     m_swap_ph = 0;
                  end
               end
               default: begin
                  if (!m_ba_hist[0]) begin
                     m_lat_x = exp_ram_rd();
                     r.hrd = 1;
                     m_lat_h = op.hr;
                     if (m_steal) begin
                        // extra compare cycle after a verify error
                        m_steal = 0;
                        if (m_len == 16'd1 && m_lat_x == m_lat_h)
                           m_status = m_status | ST_EOB;
                        m_pend[ACT_FINISH] = 1;
                     end else begin
                        step_ptrs();
                        if (m_lat_x != m_lat_h) begin
                           m_status = m_status | ST_VERR;
                           if (m_len > 16'd1) m_steal = 1;
                        end
                        count_byte();
                     end
                  end
               end
            endcase
         end
      end
      r.haddr = (r.hrd || r.hwe) ? haddr : m_hptr;
      r.dma = m_dma;
      r.irq = m_irq;
      return r;
   endfunction

   function automatic void add_op(input logic [1:0] f, input logic [4:0] a,
                                  input logic [7:0] d, input logic ba,
                                  input logic ff, input logic drain);
      bus_op_type op;
      op.func = f; op.ra = a; op.wd = d; op.ba = ba; op.ff00 = ff;
      op.hr = 8'($urandom); op.drain = drain; op.settle = 1'b0;
      op_queue.push_back(op);
   endfunction

   // ticks with FF00 strobes, repeated by the driver until the block is idle
   function automatic void add_settle();
      bus_op_type op;
      op = '0;
      op.func = FUNC_TICK; op.ff00 = 1'b1; op.hr = 8'($urandom); op.settle = 1'b1;
      op_queue.push_back(op);
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic rand_ba();
      return $urandom_range(99) < 25;
   endfunction

   // registers whose writes cannot move a transfer out of the filled window
   function automatic logic [4:0] safe_reg();
      int p;
      p = $urandom_range(2);
      if (p == 0) return REG_IRQ_MASK;
      if (p == 1) return REG_ADDR_CTL;
      return 5'($urandom_range(11, 31));
   endfunction

   // one transfer setup inside the filled window, then ticks
   function automatic void add_transfer();
      int len, nticks;
      logic [7:0] cmd;
      len = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      add_op(FUNC_WRITE, REG_HOST_LO, 8'($urandom), 0, 0, 0);
      add_op(FUNC_WRITE, REG_HOST_HI, 8'($urandom), 0, 0, 0);
      add_op(FUNC_WRITE, REG_EXP_LO, 8'($urandom_range(0, 63)), 0, 0, 0);
      add_op(FUNC_WRITE, REG_EXP_MID, 8'h00, 0, 0, 0);
      // bank bits above the RAM size are masked off, bit 16 must stay clear
      add_op(FUNC_WRITE, REG_EXP_BANK, 8'($urandom) & 8'hfe, 0, 0, 0);
      add_op(FUNC_WRITE, REG_LEN_LO, 8'(len), 0, 0, 0);
      add_op(FUNC_WRITE, REG_LEN_HI, 8'(len >> 8), 0, 0, 0);
      if ($urandom_range(3) == 0)
         add_op(FUNC_WRITE, REG_IRQ_MASK, 8'($urandom), 0, 0, 0);
      if ($urandom_range(2) == 0)
         add_op(FUNC_WRITE, REG_ADDR_CTL, 8'($urandom), 0, 0, 0);
      cmd = 8'($urandom);
      cmd[7] = ($urandom_range(9) != 0);
      add_op(FUNC_WRITE, REG_COMMAND, cmd, 0, 0, 0);
      nticks = 2 * len + 8;
      if ($urandom_range(99) < 15) nticks = $urandom_range(1, nticks);
      for (int i = 0; i < nticks; i++) begin
         if ($urandom_range(99) < 8) begin
            if ($urandom_range(1) == 0)
               add_op(FUNC_READ, 5'($urandom), 8'd0, 1'b0, 1'b0, 1'b0);
            else
               add_op(FUNC_WRITE, safe_reg(), 8'($urandom), 1'b0, 1'b0, 1'b0);
         end
         add_op(FUNC_TICK, 0, 0, rand_ba(), $urandom_range(99) < 30, 0);
      end
      add_op(FUNC_READ, REG_STATUS, 0, 0, 0, 0);
      add_settle();
   endfunction

   initial begin
      model_reset();
      // fill a 128-byte window at the bottom of expansion RAM; transfers stay in it
      add_op(FUNC_WRITE, REG_EXP_LO, 8'h00, 0, 0, 1);
      add_op(FUNC_WRITE, REG_EXP_MID, 8'h00, 0, 0, 0);
      add_op(FUNC_WRITE, REG_EXP_BANK, 8'h00, 0, 0, 0);
      add_op(FUNC_WRITE, REG_LEN_LO, 8'h80, 0, 0, 0);
      add_op(FUNC_WRITE, REG_LEN_HI, 8'h00, 0, 0, 0);
      add_op(FUNC_WRITE, REG_COMMAND, 8'h90, 0, 0, 0);
      for (int i = 0; i < FILL_TICKS; i++) add_op(FUNC_TICK, 0, 0, 0, 0, 0);
      // directed: all register reads, ignored writes, unused func, irq mask
      for (int a = 0; a <= 11; a++) add_op(FUNC_READ, 5'(a), 0, 0, 0, a == 0);
      add_op(FUNC_READ, 5'd31, 0, 0, 0, 0);
      add_op(FUNC_WRITE, REG_STATUS, 8'hff, 0, 0, 0);
      add_op(FUNC_WRITE, 5'd31, 8'hff, 0, 0, 0);
      add_op(2'd3, 5'd31, 8'hff, 1, 1, 0);
      add_op(FUNC_WRITE, REG_ADDR_CTL, 8'hc0, 0, 0, 0);
      add_op(FUNC_WRITE, REG_IRQ_MASK, 8'he0, 0, 0, 0);
      add_op(FUNC_TICK, 0, 0, 1, 1, 0);
      add_op(FUNC_READ, REG_STATUS, 0, 0, 0, 0);
      add_op(FUNC_TICK, 0, 0, 1, 0, 0);
      add_op(FUNC_WRITE, REG_ADDR_CTL, 8'h00, 0, 0, 0);
      add_op(FUNC_READ, REG_IRQ_MASK, 0, 0, 0, 0);
      // random transfers
      for (int n = 0; n < 16; n++) begin
         if (n == 8) add_op(FUNC_READ, REG_STATUS, 0, 0, 0, 1);
         add_transfer();
      end
      stim_done = 1;
   end

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("ram_expansion_dma_controller test failed");
         $finish;
      end
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      bus_op_type op;
      logic       holding;
      logic       model_busy;
      holding = req_valid && !req_ready;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            op.func = req_func; op.ra = req_reg_addr; op.wd = req_wdata;
            op.ba = req_ba_low; op.ff00 = req_cpu_ff00_write;
            op.hr = req_host_rdata; op.drain = 0; op.settle = 0;
            expected_q.push_back(predict_bus_op(op));
            send_gap = pick_gap();
         end
         model_busy = m_dma || m_wait || (m_pend != 4'd0);
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (op_queue.size() > 0 && op_queue[0].settle && !model_busy) begin
               // transfer has wound down, drop the settle entry
               op_queue.delete(0);
               req_valid <= 0;
            end else if (op_queue.size() > 0 &&
                         (!op_queue[0].drain || expected_q.size() == 0)) begin
               op = op_queue[0];
               if (!op.settle) op_queue.delete(0);
               req_valid <= 1;
               req_func <= op.func;
               req_reg_addr <= op.ra;
               req_wdata <= op.wd;
               req_ba_low <= op.ba;
               req_cpu_ff00_write <= op.ff00;
               req_host_rdata <= op.hr;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor and receiver
   int  stall_left = 0;
   int  long_hold = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      bus_result_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_rdata, rsp_open_bus, rsp_host_addr, rsp_host_rd, rsp_host_we,
                   rsp_host_wdata, rsp_dma_active, rsp_irq};
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at item %0d: expected %p, got %p",
                              results_seen, want, got);
               end
            end
         end
         // long hold just after the fill so the pipeline backs up
         if (!long_hold_done && results_seen == 150) begin
            long_hold_done = 1;
            long_hold = 400;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (op_queue.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("ram_expansion_dma_controller test passed");
      else
         $display("ram_expansion_dma_controller test failed");
      $finish;
   end

endmodule

// ===== ram_expansion_dma_controller.f =====
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/ram_expansion_dma_controller.sv
bench/tb_top.sv
